FILE: rtl/psrm_pkg.sv
// Package for the page slot replacement manager: sizes, codes, request and result types.
// No dependencies.
`timescale 1ns / 1ps
package psrm_pkg;
    localparam int VIRT_PAGES = 1024;
    localparam int PHYS_SLOTS = 16;
    localparam int USAGE_BITS = 16;
    localparam int PAGE_W = $clog2(VIRT_PAGES);
    localparam int SLOT_W = $clog2(PHYS_SLOTS);
    localparam int CNT_W  = SLOT_W + 1;

    localparam logic OP_ACCESS  = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] REG_MAX_SLOTS = 2'd0;
    localparam logic [1:0] REG_POLICY    = 2'd1;
    localparam logic [1:0] REG_WB_MODE   = 2'd2;

    typedef struct packed {
        logic              opcode;
        logic [PAGE_W-1:0] virtual_page;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [3:0]        slot;
        logic              load_needed;
        logic              writeback_needed;
        logic [PAGE_W-1:0] evicted_page;
        logic              status;
    } rsp_t;
endpackage

FILE: rtl/psrm_if.sv
// Valid/ready channel interfaces, each carrying one payload (request or result).
// Depends on psrm_pkg.
`timescale 1ns / 1ps
interface psrm_req_if;
    import psrm_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface psrm_rsp_if;
    import psrm_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/page_slot_replacement_manager.sv
// Page slot replacement manager top level.
// Result paths: release, hit, fill, and replacement (a scan that skips locked slots,
//   preceded in aged mode by a one-time insertion sort of the slots in use).
// One transfer at a time: the next request is taken only after the result has left.
// Reset: async active low; after reset a pass clears all 1024 page map entries,
//   during which no request is taken. Depends on psrm_pkg and psrm_if.
`timescale 1ns / 1ps
module page_slot_replacement_manager
    import psrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    psrm_req_if.sink    req,
    psrm_rsp_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_LOOK   = 10'b0000000100,
        S_DECIDE = 10'b0000001000,
        S_SORT   = 10'b0000010000,
        S_SCAN   = 10'b0000100000,
        S_EVICT  = 10'b0001000000,
        S_MAP    = 10'b0010000000,
        S_OUT    = 10'b0100000000,
        S_SHIFT  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // config registers
    logic [4:0] max_slots_reg;
    logic       policy_reg, wb_mode_reg;

    // page map memory: {valid, slot}
    logic [SLOT_W:0]   map_mem [VIRT_PAGES];
    logic [SLOT_W:0]   map_rd_reg;
    logic              map_we;
    logic [PAGE_W-1:0] map_wa;
    logic [SLOT_W:0]   map_wd;
    logic [PAGE_W-1:0] map_ra;
    logic [PAGE_W-1:0] clr_reg;

    logic [PAGE_W-1:0]     owner_reg [PHYS_SLOTS];
    logic [USAGE_BITS-1:0] usage_reg [PHYS_SLOTS];
    logic [PHYS_SLOTS-1:0] locked_reg;
    logic [SLOT_W-1:0]     order_reg [PHYS_SLOTS];
    logic [SLOT_W-1:0]     ptr_reg;
    logic [CNT_W-1:0]      skip_reg, in_use_reg;
    logic                  order_done_reg;

    logic [PAGE_W-1:0] page_reg;
    rsp_t              out_reg;
    logic              out_valid_reg;

    // sort: insertion sort, one compare per cycle
    logic [CNT_W-1:0]  si_reg, sj_reg;
    logic [SLOT_W-1:0] skey_reg;
    logic [SLOT_W-1:0] victim_reg;

    logic [CNT_W-1:0] limit;
    always_comb
    begin
        if (max_slots_reg == 5'd0)
            limit = CNT_W'(1);
        else if (max_slots_reg > 5'(PHYS_SLOTS))
            limit = CNT_W'(PHYS_SLOTS);
        else
            limit = CNT_W'(max_slots_reg);
    end

    assign pready = 1'b1;
    always_comb
    begin
        case (paddr[3:2])
            REG_MAX_SLOTS: prdata = {27'd0, max_slots_reg};
            REG_POLICY:    prdata = {31'd0, policy_reg};
            REG_WB_MODE:   prdata = {31'd0, wb_mode_reg};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_slots_reg <= 5'd16;
            policy_reg    <= 1'b0;
            wb_mode_reg   <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_MAX_SLOTS: max_slots_reg <= pwdata[4:0];
                REG_POLICY:    policy_reg    <= pwdata[0];
                REG_WB_MODE:   wb_mode_reg   <= pwdata[0];
                default:       ;
            endcase
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    logic [SLOT_W-1:0] ord_at_ptr;
    assign ord_at_ptr = order_reg[ptr_reg];
    logic [SLOT_W-1:0] ptr_inc;
    assign ptr_inc = ptr_reg + 1'b1;

    // map memory ports
    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_wa] <= map_wd;
        map_rd_reg <= map_mem[map_ra];
    end

    always_comb
    begin
        map_we = 1'b0;
        map_wa = page_reg;
        map_wd = '0;
        // input page while idle, then the latched page once the input side moves on
        map_ra = (state_reg == S_IDLE) ? req.data.virtual_page : page_reg;
        case (state_reg)
            S_CLEAR:
            begin
                map_we = 1'b1;
                map_wa = clr_reg;
            end
            S_EVICT:
            begin
                // unmap the old owner
                map_we = 1'b1;
                map_wa = owner_reg[victim_reg];
            end
            S_MAP:
            begin
                map_we = 1'b1;
                map_wd = {1'b1, victim_reg};
            end
            default: ;
        endcase
    end

    logic sort_move;
    assign sort_move = (sj_reg != '0) &&
        (usage_reg[order_reg[SLOT_W'(sj_reg - 1'b1)]] > usage_reg[skey_reg]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            locked_reg     <= '0;
            ptr_reg        <= '0;
            skip_reg       <= '0;
            in_use_reg     <= '0;
            order_done_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < PHYS_SLOTS; i++)
                order_reg[i] <= SLOT_W'(i);
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == PAGE_W'(VIRT_PAGES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        page_reg <= req.data.virtual_page;
                        out_reg  <= '0;
                        if (req.data.opcode == OP_RELEASE)
                        begin
                            locked_reg     <= '0;
                            skip_reg       <= '0;
                            order_done_reg <= 1'b0;
                            state_reg      <= S_OUT;
                        end
                        else
                            state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                    state_reg <= S_DECIDE;
                S_DECIDE:
                begin
                    if (map_rd_reg[SLOT_W])
                    begin
                        if (usage_reg[map_rd_reg[SLOT_W-1:0]] != '1)
                            usage_reg[map_rd_reg[SLOT_W-1:0]] <=
                                usage_reg[map_rd_reg[SLOT_W-1:0]] + 1'b1;
                        locked_reg[map_rd_reg[SLOT_W-1:0]] <= 1'b1;
                        out_reg.hit  <= 1'b1;
                        out_reg.slot <= 4'(map_rd_reg[SLOT_W-1:0]);
                        state_reg    <= S_OUT;
                    end
                    else if (in_use_reg < limit)
                    begin
                        victim_reg <= SLOT_W'(in_use_reg);
                        order_reg[SLOT_W'(in_use_reg)] <= SLOT_W'(in_use_reg);
                        in_use_reg <= in_use_reg + 1'b1;
                        state_reg  <= S_MAP;
                    end
                    else if (policy_reg && !order_done_reg)
                    begin
                        for (int i = 0; i < PHYS_SLOTS; i++)
                            if (CNT_W'(i) < in_use_reg)
                                order_reg[i] <= SLOT_W'(i);
                        si_reg    <= CNT_W'(1);
                        sj_reg    <= CNT_W'(1);
                        skey_reg  <= SLOT_W'(1);
                        state_reg <= S_SORT;
                    end
                    else
                    begin
                        if (CNT_W'(ptr_reg) >= limit)
                            ptr_reg <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SORT:
                begin
                    if (si_reg >= in_use_reg)
                    begin
                        order_done_reg <= 1'b1;
                        if (CNT_W'(ptr_reg) >= limit)
                            ptr_reg <= '0;
                        state_reg <= S_SCAN;
                    end
                    else if (sort_move)
                    begin
                        order_reg[SLOT_W'(sj_reg)] <= order_reg[SLOT_W'(sj_reg - 1'b1)];
                        sj_reg <= sj_reg - 1'b1;
                    end
                    else
                    begin
                        order_reg[SLOT_W'(sj_reg)] <= skey_reg;
                        si_reg   <= si_reg + 1'b1;
                        sj_reg   <= si_reg + 1'b1;
                        skey_reg <= order_reg[SLOT_W'(si_reg + 1'b1)];
                    end
                end
                S_SCAN:
                begin
                    if (skip_reg >= limit)
                    begin
                        out_reg.status <= 1'b1;
                        state_reg      <= S_OUT;
                    end
                    else if (locked_reg[ord_at_ptr])
                    begin
                        skip_reg <= skip_reg + 1'b1;
                        ptr_reg  <= (CNT_W'(ptr_inc) >= limit || ptr_inc == '0)
                                    ? '0 : ptr_inc;
                    end
                    else
                    begin
                        victim_reg <= ord_at_ptr;
                        ptr_reg    <= ptr_inc;
                        state_reg  <= S_EVICT;
                    end
                end
                S_EVICT:
                begin
                    out_reg.writeback_needed <= wb_mode_reg;
                    out_reg.evicted_page     <= owner_reg[victim_reg];
                    state_reg                <= S_MAP;
                end
                S_MAP:
                begin
                    owner_reg[victim_reg]  <= page_reg;
                    usage_reg[victim_reg]  <= USAGE_BITS'(1);
                    locked_reg[victim_reg] <= 1'b1;
                    out_reg.slot           <= 4'(victim_reg);
                    out_reg.load_needed    <= 1'b1;
                    state_reg              <= S_OUT;
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_SHIFT;
                end
                S_SHIFT:
                begin
                    if (rsp.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/psrm_checker.sv
// Port-level checker for the page slot replacement manager, with its bind.
// Depends on psrm_pkg.
`timescale 1ns / 1ps
module psrm_checker
    import psrm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_data
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result dropped while stalled");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(rsp_valid && req_ready))
        else $error("input taken while result pending");
    a_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.hit |-> !rsp_data.load_needed && !rsp_data.status)
        else $error("hit with load or refusal");
    a_ref: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status |-> rsp_data.slot == '0 && !rsp_data.hit)
        else $error("refusal carries data");
endmodule

bind page_slot_replacement_manager psrm_checker u_psrm_checker (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

FILE: tb/tb_page_slot_replacement_manager.sv
// Testbench for the page slot replacement manager: directed table, aged order, then random phases
// under several register settings, checked against typed results or an in-bench slot map model.
// Depends on psrm_pkg, psrm_if and the page_slot_replacement_manager RTL.
`timescale 1ns / 1ps
module tb_page_slot_replacement_manager;
    import psrm_pkg::*;

    // One row of the directed table. When has_exp is set the typed result is
    // expected; otherwise the slot map model supplies it.
    typedef struct {
        logic              opcode;
        logic [PAGE_W-1:0] page;
        bit                has_exp;
        rsp_t              exp;
    } dir_row_t;

    // One random phase: register setting, idling percentages and item count.
    typedef struct {
        logic [4:0] max_slots;
        logic       policy;
        logic       wb_mode;
        int         idle_pct;
        int         stall_pct;
        int         items;
    } phase_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    psrm_req_if req_if ();
    psrm_rsp_if rsp_if ();

    page_slot_replacement_manager u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Slot map model: register copies and state mirrored from the block.
    // ------------------------------------------------------------------
    logic [4:0]          cfg_max_slots = 5'd16;
    logic                cfg_policy    = 1'b0;
    logic                cfg_wb_mode   = 1'b0;
    bit                  page_mapped [VIRT_PAGES];
    logic [SLOT_W-1:0]   page_slot   [VIRT_PAGES];
    logic [PAGE_W-1:0]   owner_page  [PHYS_SLOTS];
    logic [USAGE_BITS-1:0] usage     [PHYS_SLOTS];
    bit                  locked      [PHYS_SLOTS];
    logic [SLOT_W-1:0]   victim_seq  [PHYS_SLOTS];
    int                  hand;
    int                  skips;
    int                  used_slots;
    bit                  seq_sorted;

    rsp_t expected_rsps[$];
    int   mismatches = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;

    function automatic int active_limit();
        if (cfg_max_slots == 0)
            return 1;
        if (cfg_max_slots > PHYS_SLOTS)
            return PHYS_SLOTS;
        return cfg_max_slots;
    endfunction

    // Stable insertion sort of the occupied slots by usage, lower slot first on ties.
    function automatic void sort_by_usage();
        int n;
        int j;
        logic [SLOT_W-1:0] s;
        n = used_slots;
        for (int i = 0; i < n; i++)
            victim_seq[i] = SLOT_W'(i);
        for (int i = 1; i < n; i++)
        begin
            s = victim_seq[i];
            j = i;
            while (j > 0 && usage[victim_seq[j-1]] > usage[s])
            begin
                victim_seq[j] = victim_seq[j-1];
                j--;
            end
            victim_seq[j] = s;
        end
        seq_sorted = 1'b1;
    endfunction

    function automatic rsp_t map_page(logic opcode, logic [PAGE_W-1:0] page);
        rsp_t r;
        int lim;
        logic [SLOT_W-1:0] s;
        logic [PAGE_W-1:0] old;
        r = '0;
        lim = active_limit();
        if (opcode == OP_RELEASE)
        begin
            foreach (locked[i])
                locked[i] = 1'b0;
            skips = 0;
            seq_sorted = 1'b0;
            return r;
        end
        if (page_mapped[page])
        begin
            s = page_slot[page];
            if (usage[s] != {USAGE_BITS{1'b1}})
                usage[s] = usage[s] + 1'b1;
            locked[s] = 1'b1;
            r.hit = 1'b1;
            r.slot = s;
            return r;
        end
        if (used_slots < lim)
        begin
            s = SLOT_W'(used_slots);
            owner_page[s] = page;
            usage[s] = USAGE_BITS'(1);
            victim_seq[s] = s;
            locked[s] = 1'b1;
            page_mapped[page] = 1'b1;
            page_slot[page] = s;
            used_slots++;
            r.slot = s;
            r.load_needed = 1'b1;
            return r;
        end
        if (cfg_policy && !seq_sorted)
            sort_by_usage();
        if (hand >= lim)
            hand = 0;
        while (skips < lim && locked[victim_seq[hand]])
        begin
            hand++;
            skips++;
            if (hand >= lim)
                hand = 0;
        end
        // every candidate locked since the last release: refuse
        if (skips >= lim)
        begin
            r.status = 1'b1;
            return r;
        end
        s = victim_seq[hand];
        old = owner_page[s];
        page_mapped[old] = 1'b0;
        page_mapped[page] = 1'b1;
        page_slot[page] = s;
        owner_page[s] = page;
        usage[s] = USAGE_BITS'(1);
        locked[s] = 1'b1;
        hand++;
        if (hand >= PHYS_SLOTS)
            hand = 0;
        r.slot = s;
        r.load_needed = 1'b1;
        r.writeback_needed = cfg_wb_mode;
        r.evicted_page = old;
        return r;
    endfunction

    function automatic rsp_t mk_rsp(logic h, logic [3:0] s, logic ld, logic wb,
                                    logic [PAGE_W-1:0] ev, logic st);
        rsp_t r;
        r.hit = h;
        r.slot = s;
        r.load_needed = ld;
        r.writeback_needed = wb;
        r.evicted_page = ev;
        r.status = st;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driving tasks. Inputs change on the falling edge only.
    // ------------------------------------------------------------------
    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_MAX_SLOTS: cfg_max_slots = value[4:0];
            REG_POLICY:    cfg_policy = value[0];
            REG_WB_MODE:   cfg_wb_mode = value[0];
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Entered right after a rising edge; returns at the accepting edge.
    // When use_typed is set the typed result is queued instead of the model's.
    task automatic send_req(logic opcode, logic [PAGE_W-1:0] page, bit use_typed,
                            rsp_t typed);
        rsp_t r;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data.opcode <= opcode;
        req_if.data.virtual_page <= page;
        do
            @(posedge clk);
        while (!req_if.ready);
        r = map_page(opcode, page);
        expected_rsps.push_back(use_typed ? typed : r);
    endtask

    task automatic drain();
        @(negedge clk);
        req_if.valid <= 1'b0;
        wait (expected_rsps.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, check every transfer against the oldest
    // expectation.
    // ------------------------------------------------------------------
    always @(negedge clk)
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        rsp_t e;
        rsp_t a;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            a = rsp_if.data;
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %p", a);
            end
            else
            begin
                e = expected_rsps.pop_front();
                if (a.hit !== e.hit || a.slot !== e.slot
                    || a.load_needed !== e.load_needed
                    || a.writeback_needed !== e.writeback_needed
                    || a.evicted_page !== e.evicted_page || a.status !== e.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: expected %p, got %p", $time, e, a);
                end
            end
        end
    end

    initial
    begin
        #10ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        dir_row_t dir_rows[$];
        phase_t   phases[$];
        rsp_t     none;
        int       lim;
        int       base;
        int       roll;
        logic [PAGE_W-1:0] pg;

        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
        none = '0;
        foreach (page_mapped[i])
        begin
            page_mapped[i] = 1'b0;
            page_slot[i] = '0;
        end
        foreach (locked[i])
        begin
            locked[i] = 1'b0;
            victim_seq[i] = SLOT_W'(i);
            owner_page[i] = '0;
            usage[i] = '0;
        end
        hand = 0;
        skips = 0;
        used_slots = 0;
        seq_sorted = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Two slots, read-write mode: fills, a hit, refusal with everything
        // locked, release, replacement with write-back, then refusal again.
        reg_write(REG_MAX_SLOTS, 32'd2);
        reg_write(REG_WB_MODE, 32'd1);
        dir_rows.push_back('{OP_ACCESS, 10'd0, 1'b1,
                             mk_rsp(1'b0, 4'd0, 1'b1, 1'b0, 10'd0, 1'b0)});
        dir_rows.push_back('{OP_ACCESS, 10'd1023, 1'b1,
                             mk_rsp(1'b0, 4'd1, 1'b1, 1'b0, 10'd0, 1'b0)});
        dir_rows.push_back('{OP_ACCESS, 10'd0, 1'b1,
                             mk_rsp(1'b1, 4'd0, 1'b0, 1'b0, 10'd0, 1'b0)});
        dir_rows.push_back('{OP_ACCESS, 10'd5, 1'b1,
                             mk_rsp(1'b0, 4'd0, 1'b0, 1'b0, 10'd0, 1'b1)});
        dir_rows.push_back('{OP_RELEASE, 10'd1023, 1'b1,
                             mk_rsp(1'b0, 4'd0, 1'b0, 1'b0, 10'd0, 1'b0)});
        dir_rows.push_back('{OP_ACCESS, 10'd5, 1'b1,
                             mk_rsp(1'b0, 4'd0, 1'b1, 1'b1, 10'd0, 1'b0)});
        dir_rows.push_back('{OP_ACCESS, 10'd1023, 1'b1,
                             mk_rsp(1'b1, 4'd1, 1'b0, 1'b0, 10'd0, 1'b0)});
        dir_rows.push_back('{OP_ACCESS, 10'd0, 1'b1,
                             mk_rsp(1'b0, 4'd0, 1'b0, 1'b0, 10'd0, 1'b1)});
        dir_rows.push_back('{OP_RELEASE, 10'd0, 1'b0, none});
        dir_rows.push_back('{OP_ACCESS, 10'h2AA, 1'b0, none});
        dir_rows.push_back('{OP_ACCESS, 10'h155, 1'b0, none});
        dir_rows.push_back('{OP_ACCESS, 10'h2AA, 1'b0, none});
        foreach (dir_rows[i])
            send_req(dir_rows[i].opcode, dir_rows[i].page, dir_rows[i].has_exp,
                     dir_rows[i].exp);
        drain();

        // Aged order: raise the limit, build uneven usage, then replace.
        reg_write(REG_MAX_SLOTS, 32'd4);
        reg_write(REG_POLICY, 32'd1);
        reg_write(REG_WB_MODE, 32'd0);
        send_req(OP_ACCESS, 10'd40, 1'b0, none);
        send_req(OP_ACCESS, 10'd41, 1'b0, none);
        send_req(OP_ACCESS, 10'd41, 1'b0, none);
        send_req(OP_ACCESS, 10'd41, 1'b0, none);
        send_req(OP_ACCESS, 10'd40, 1'b0, none);
        send_req(OP_RELEASE, 10'd0, 1'b0, none);
        send_req(OP_ACCESS, 10'd77, 1'b0, none);
        send_req(OP_ACCESS, 10'd78, 1'b0, none);
        send_req(OP_ACCESS, 10'd79, 1'b0, none);
        drain();

        // Random phases over setting extremes and idling patterns.
        phases.push_back('{5'd16, 1'b0, 1'b0,  0,  0, 150});
        phases.push_back('{5'd0,  1'b1, 1'b1, 62,  0, 130});
        phases.push_back('{5'd31, 1'b1, 1'b0,  0, 62, 150});
        phases.push_back('{5'd5,  1'b1, 1'b1,  9,  9, 150});
        phases.push_back('{5'd1,  1'b0, 1'b1,  0,  0, 130});
        phases.push_back('{5'd8,  1'b0, 1'b0, 62,  0, 150});
        phases.push_back('{5'd3,  1'b1, 1'b0,  0, 62, 150});
        phases.push_back('{5'd12, 1'b0, 1'b1,  9,  9, 150});

        foreach (phases[p])
        begin
            reg_write(REG_MAX_SLOTS,
                      {24'd0, 3'($urandom_range(7)), phases[p].max_slots});
            reg_write(REG_POLICY, {31'd0, phases[p].policy});
            reg_write(REG_WB_MODE, {31'd0, phases[p].wb_mode});
            idle_pct = phases[p].idle_pct;
            stall_pct = phases[p].stall_pct;
            lim = active_limit();
            base = $urandom_range(VIRT_PAGES - 1);
            for (int n = 0; n < phases[p].items; n++)
            begin
                // hold off the sender once until every result is back
                if (p == 1 && n == 60)
                begin
                    @(negedge clk);
                    req_if.valid <= 1'b0;
                    wait (expected_rsps.size() == 0);
                    @(posedge clk);
                end
                // hot window of pages near the slot count keeps hits and
                // replacements frequent; some fully random pages too
                roll = $urandom_range(99);
                if (roll < 80)
                    pg = PAGE_W'(base + $urandom_range(lim + 3));
                else
                    pg = PAGE_W'($urandom_range(VIRT_PAGES - 1));
                if (roll >= 80 && roll < 93)
                    send_req(OP_RELEASE, pg, 1'b0, none);
                else
                    send_req(OP_ACCESS, pg, 1'b0, none);
            end
            drain();
        end

        idle_pct = 0;
        stall_pct = 0;
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/psrm_pkg.sv
rtl/psrm_if.sv
rtl/page_slot_replacement_manager.sv
rtl/psrm_checker.sv
tb/tb_page_slot_replacement_manager.sv
